FILE: design/hng_pkg.sv
// shared types and constants of the heightmap normal generator
`default_nettype none

package hng_pkg;

  localparam int HEIGHT_W          = 8;
  localparam int SCALE_W           = 16;
  localparam int DIM_CFG_W         = 13;
  localparam int COORD_W           = 12;
  localparam int NX_W              = 16;
  localparam int NY_W              = 15;
  localparam int DIFF_W            = HEIGHT_W + 1;
  localparam int PROD_W            = 26;
  localparam int SQ_W              = 48;
  localparam int S_W               = 50;
  localparam int MIN_DIM           = 3;
  localparam int MAX_ROWS          = 4096;
  localparam int DEFAULT_MAX_WIDTH = 4096;
  localparam int DEFAULT_FRAC_BITS = 14;
  localparam int UNIT_SQ           = 65536;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [SCALE_W-1:0]   RST_HEIGHT_SCALE = 16'd256;
  localparam logic [DIM_CFG_W-1:0] RST_IMAGE_WIDTH  = 13'd256;
  localparam logic [DIM_CFG_W-1:0] RST_IMAGE_HEIGHT = 13'd256;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               interior;
    logic               last;
    logic               neg_x;
    logic               neg_z;
  } meta_t;

  typedef struct packed {
    logic signed [NX_W-1:0] normal_x;
    logic [NY_W-1:0]        normal_y;
    logic signed [NX_W-1:0] normal_z;
    logic [COORD_W-1:0]     column;
    logic [COORD_W-1:0]     row;
    logic                   interior;
    logic                   last;
  } result_t;

endpackage

`default_nettype wire

FILE: design/hng_root_step.sv
// one bit of the rounded unit-vector search for all three components
`default_nettype none

module hng_root_step #(
  parameter int FRAC_BITS = hng_pkg::DEFAULT_FRAC_BITS,
  parameter int BIT       = 0,
  localparam int RW       = 2 * FRAC_BITS + 56,
  localparam int QW       = FRAC_BITS + 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire hng_pkg::meta_t        in_meta,
  input  wire logic [hng_pkg::S_W-1:0] in_s,
  input  wire logic signed [RW-1:0]  in_rem  [3],
  input  wire logic signed [RW-1:0]  in_tsum [3],
  input  wire logic [QW-1:0]         in_quo  [3],
  output logic                       out_valid,
  output hng_pkg::meta_t             out_meta,
  output logic [hng_pkg::S_W-1:0]    out_s,
  output logic signed [RW-1:0]       out_rem  [3],
  output logic signed [RW-1:0]       out_tsum [3],
  output logic [QW-1:0]              out_quo  [3]
);
  import hng_pkg::*;

  logic signed [RW-1:0] s_ext;
  logic signed [RW-1:0] trial [3];
  logic                 take  [3];

  // residual p^2 - (2q-1)^2 s, updated when bit BIT of q is tried
  always_comb begin
    s_ext = $signed(RW'(in_s));
    for (int c = 0; c < 3; c++) begin
      trial[c] = in_rem[c] - (in_tsum[c] <<< (BIT + 2)) - (s_ext <<< (2 * BIT + 2));
      take[c]  = !trial[c][RW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_meta <= in_meta;
      out_s    <= in_s;
      for (int c = 0; c < 3; c++) begin
        if (take[c]) begin
          out_rem[c]  <= trial[c];
          out_tsum[c] <= in_tsum[c] + (s_ext <<< (BIT + 1));
          out_quo[c]  <= in_quo[c] | (QW'(1) << BIT);
        end else begin
          out_rem[c]  <= in_rem[c];
          out_tsum[c] <= in_tsum[c];
          out_quo[c]  <= in_quo[c];
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/heightmap_normal_generator.sv
// top level: line buffer, central differences and pipelined normalization
//
//   port group   dir  beat carries
//   in_*         in   one height byte, raster order
//   out_*        out  one normal with pixel position and flags
//   cfg_*        in   register index and write data
//
// one sample per cycle while in_ready is high; after stages a to d a normal
// passes one stage per bit of the unit search, then the output register
// a write of image_width holds in_ready low while the line buffer prefetch
// is reloaded at the current column
// rst_n clears counters, config registers and valid bits; the line buffer is not
// cleared and the first two rows never use its contents for interior pixels
// a stalled output fills a one-entry skid register, then the pipeline holds
`default_nettype none

module heightmap_normal_generator #(
  parameter int MAX_WIDTH        = hng_pkg::DEFAULT_MAX_WIDTH,
  parameter int NORMAL_FRAC_BITS = hng_pkg::DEFAULT_FRAC_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [hng_pkg::HEIGHT_W-1:0]      in_height_sample,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [hng_pkg::NX_W-1:0]        out_normal_x,
  output logic [hng_pkg::NY_W-1:0]               out_normal_y,
  output logic signed [hng_pkg::NX_W-1:0]        out_normal_z,
  output logic [hng_pkg::COORD_W-1:0]            out_column,
  output logic [hng_pkg::COORD_W-1:0]            out_row,
  output logic                                   out_interior,
  output logic                                   out_last_out,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [hng_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hng_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import hng_pkg::*;

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int LW    = ($clog2(MAX_WIDTH + 1) > DIM_CFG_W) ? $clog2(MAX_WIDTH + 1) : DIM_CFG_W;
  localparam int RW    = 2 * NORMAL_FRAC_BITS + 56;
  localparam int QW    = NORMAL_FRAC_BITS + 1;
  localparam int NSTEP = NORMAL_FRAC_BITS + 1;

  localparam logic [1:0] RF_IDLE  = 2'd0;
  localparam logic [1:0] RF_LAST  = 2'd1;
  localparam logic [1:0] RF_FIRST = 2'd2;

  // configuration
  logic [SCALE_W-1:0]   scale_r;
  logic [DIM_CFG_W-1:0] width_cfg_r;
  logic [DIM_CFG_W-1:0] height_cfg_r;
  logic                 cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r      <= RST_HEIGHT_SCALE;
      width_cfg_r  <= RST_IMAGE_WIDTH;
      height_cfg_r <= RST_IMAGE_HEIGHT;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_HEIGHT_SCALE: scale_r      <= cfg_data[SCALE_W-1:0];
        REG_IMAGE_WIDTH:  width_cfg_r  <= cfg_data[DIM_CFG_W-1:0];
        REG_IMAGE_HEIGHT: height_cfg_r <= cfg_data[DIM_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LW-1:0]        w_eff;
  logic [DIM_CFG_W-1:0] h_eff;

  always_comb begin
    if (width_cfg_r < DIM_CFG_W'(MIN_DIM)) w_eff = LW'(MIN_DIM);
    else if (LW'(width_cfg_r) > LW'(MAX_WIDTH)) w_eff = LW'(MAX_WIDTH);
    else w_eff = LW'(width_cfg_r);
    if (height_cfg_r < DIM_CFG_W'(MIN_DIM)) h_eff = DIM_CFG_W'(MIN_DIM);
    else if (height_cfg_r > DIM_CFG_W'(MAX_ROWS)) h_eff = DIM_CFG_W'(MAX_ROWS);
    else h_eff = height_cfg_r;
  end

  // raster position and window
  logic [AW-1:0]         col_r;
  logic [COORD_W-1:0]    row_r;
  logic [HEIGHT_W-1:0]   prev_r;
  logic [1:0]            refill_r;
  logic                  skid_full_r;
  logic                  adv;
  logic                  in_fire;
  logic [2*HEIGHT_W-1:0] rdata_r;
  logic [2*HEIGHT_W-1:0] cur_r;

  logic [LW-1:0]        col_inc;
  logic                 col_wrap;
  logic [AW-1:0]        n1;
  logic [LW-1:0]        n1_inc;
  logic [AW-1:0]        n2;
  logic [DIM_CFG_W-1:0] row_inc;
  logic                 row_wrap;
  logic                 interior_s;
  logic                 last_s;

  assign adv      = !skid_full_r;
  assign in_ready = adv && (refill_r == RF_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    col_inc    = LW'(col_r) + LW'(1);
    col_wrap   = col_inc >= w_eff;
    n1         = col_wrap ? '0 : AW'(col_inc);
    n1_inc     = LW'(n1) + LW'(1);
    n2         = (n1_inc >= w_eff) ? '0 : AW'(n1_inc);
    row_inc    = DIM_CFG_W'(row_r) + DIM_CFG_W'(1);
    row_wrap   = row_inc >= h_eff;
    interior_s = (row_r >= COORD_W'(2)) && (col_r != '0) && !col_wrap;
    last_s     = row_wrap && col_wrap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      prev_r <= '0;
    end else if (in_fire) begin
      if (col_wrap) begin
        col_r  <= '0;
        prev_r <= '0;
        row_r  <= row_wrap ? '0 : COORD_W'(row_inc);
      end else begin
        col_r  <= AW'(col_inc);
        prev_r <= cur_r[HEIGHT_W-1:0];
      end
    end
  end

  // reload of the two prefetched buffer words after a width change
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refill_r <= RF_IDLE;
    end else if (cfg_fire && cfg_index == REG_IMAGE_WIDTH) begin
      refill_r <= RF_FIRST;
    end else begin
      unique case (refill_r)
        RF_FIRST: refill_r <= RF_LAST;
        RF_LAST:  refill_r <= RF_IDLE;
        default:  refill_r <= RF_IDLE;
      endcase
    end
  end

  // line buffer word: upper row byte over middle row byte
  logic [2*HEIGHT_W-1:0] line_mem [MAX_WIDTH];
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;

  assign rd_en   = in_fire || (refill_r != RF_IDLE);
  assign rd_addr = in_fire ? n2 : ((refill_r == RF_FIRST) ? col_r : n1);

  // cur_r holds the word of the current column, rdata_r that of the next
  always_ff @(posedge clk) begin
    if (in_fire) line_mem[col_r] <= {cur_r[HEIGHT_W-1:0], in_height_sample};
    if (rd_en) rdata_r <= line_mem[rd_addr];
    if (in_fire || refill_r == RF_LAST) cur_r <= rdata_r;
  end

  // stage a: differences
  logic                     a_valid_r;
  meta_t                    a_meta_r;
  logic signed [DIFF_W-1:0] a_dx_r;
  logic signed [DIFF_W-1:0] a_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_valid_r <= 1'b0;
    else if (adv) a_valid_r <= in_fire && (row_r != '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_meta_r.column   <= COORD_W'(col_r);
      a_meta_r.row      <= row_r - COORD_W'(1);
      a_meta_r.interior <= interior_s;
      a_meta_r.last     <= last_s;
      a_meta_r.neg_x    <= 1'b0;
      a_meta_r.neg_z    <= 1'b0;
      a_dx_r <= $signed({1'b0, rdata_r[HEIGHT_W-1:0]}) - $signed({1'b0, prev_r});
      a_dz_r <= $signed({1'b0, in_height_sample}) - $signed({1'b0, cur_r[2*HEIGHT_W-1:HEIGHT_W]});
    end
  end

  // stage b: scale
  logic                     b_valid_r;
  meta_t                    b_meta_r;
  logic signed [PROD_W-1:0] b_dx_r;
  logic signed [PROD_W-1:0] b_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_valid_r <= 1'b0;
    else if (adv) b_valid_r <= a_valid_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_meta_r <= a_meta_r;
      b_dx_r   <= $signed({1'b0, scale_r}) * a_dx_r;
      b_dz_r   <= $signed({1'b0, scale_r}) * a_dz_r;
    end
  end

  // stage c: squares
  logic                       c_valid_r;
  meta_t                      c_meta_r;
  meta_t                      c_meta_nxt;
  logic [SQ_W-1:0]            c_sqx_r;
  logic [SQ_W-1:0]            c_sqz_r;
  logic signed [2*PROD_W-1:0] sqx_full;
  logic signed [2*PROD_W-1:0] sqz_full;

  assign sqx_full = b_dx_r * b_dx_r;
  assign sqz_full = b_dz_r * b_dz_r;

  always_comb begin
    c_meta_nxt       = b_meta_r;
    c_meta_nxt.neg_x = !b_dx_r[PROD_W-1] && (b_dx_r != '0);
    c_meta_nxt.neg_z = !b_dz_r[PROD_W-1] && (b_dz_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c_valid_r <= 1'b0;
    else if (adv) c_valid_r <= b_valid_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_meta_r <= c_meta_nxt;
      c_sqx_r  <= sqx_full[SQ_W-1:0];
      c_sqz_r  <= sqz_full[SQ_W-1:0];
    end
  end

  // stage d: norm square and starting residuals, then one stage per bit
  logic                 st_valid [NSTEP+1];
  meta_t                st_meta  [NSTEP+1];
  logic [S_W-1:0]       st_s     [NSTEP+1];
  logic signed [RW-1:0] st_rem   [NSTEP+1][3];
  logic signed [RW-1:0] st_tsum  [NSTEP+1][3];
  logic [QW-1:0]        st_quo   [NSTEP+1][3];

  logic [S_W-1:0]       s_sum;
  logic signed [RW-1:0] s_wide;

  assign s_sum  = S_W'(c_sqx_r) + S_W'(c_sqz_r) + S_W'(UNIT_SQ);
  assign s_wide = $signed(RW'(s_sum));

  always_ff @(posedge clk) begin
    if (!rst_n) st_valid[0] <= 1'b0;
    else if (adv) st_valid[0] <= c_valid_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_meta[0]    <= c_meta_r;
      st_s[0]       <= s_sum;
      st_rem[0][0]  <= $signed(RW'(c_sqx_r) << (2 * NORMAL_FRAC_BITS + 2)) - s_wide;
      st_rem[0][1]  <= $signed(RW'(UNIT_SQ) << (2 * NORMAL_FRAC_BITS + 2)) - s_wide;
      st_rem[0][2]  <= $signed(RW'(c_sqz_r) << (2 * NORMAL_FRAC_BITS + 2)) - s_wide;
      for (int c = 0; c < 3; c++) begin
        st_tsum[0][c] <= -s_wide;
        st_quo[0][c]  <= '0;
      end
    end
  end

  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    hng_root_step #(
      .FRAC_BITS (NORMAL_FRAC_BITS),
      .BIT       (NORMAL_FRAC_BITS - g)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (st_valid[g]),
      .in_meta   (st_meta[g]),
      .in_s      (st_s[g]),
      .in_rem    (st_rem[g]),
      .in_tsum   (st_tsum[g]),
      .in_quo    (st_quo[g]),
      .out_valid (st_valid[g+1]),
      .out_meta  (st_meta[g+1]),
      .out_s     (st_s[g+1]),
      .out_rem   (st_rem[g+1]),
      .out_tsum  (st_tsum[g+1]),
      .out_quo   (st_quo[g+1])
    );
  end

  // result assembly
  meta_t              fin_meta;
  logic signed [QW:0] qx_s;
  logic signed [QW:0] qz_s;
  result_t            res_nxt;

  always_comb begin
    fin_meta = st_meta[NSTEP];
    qx_s     = $signed({1'b0, st_quo[NSTEP][0]});
    qz_s     = $signed({1'b0, st_quo[NSTEP][2]});
    res_nxt.column   = fin_meta.column;
    res_nxt.row      = fin_meta.row;
    res_nxt.interior = fin_meta.interior;
    res_nxt.last     = fin_meta.last;
    if (fin_meta.interior) begin
      res_nxt.normal_x = NX_W'(fin_meta.neg_x ? -qx_s : qx_s);
      res_nxt.normal_y = NY_W'(st_quo[NSTEP][1]);
      res_nxt.normal_z = NX_W'(fin_meta.neg_z ? -qz_s : qz_s);
    end else begin
      res_nxt.normal_x = '0;
      res_nxt.normal_y = '0;
      res_nxt.normal_z = '0;
    end
  end

  // output register with skid entry
  logic    out_valid_r;
  result_t out_res_r;
  result_t skid_res_r;
  logic    out_fire;
  logic    pipe_done;

  assign out_fire  = out_valid_r && out_ready;
  assign pipe_done = adv && st_valid[NSTEP];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (out_fire) skid_full_r <= 1'b0;
    end else if (pipe_done) begin
      if (!out_valid_r || out_ready) out_valid_r <= 1'b1;
      else skid_full_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r && out_fire) begin
      out_res_r <= skid_res_r;
    end else if (pipe_done && (!out_valid_r || out_ready)) begin
      out_res_r <= res_nxt;
    end
    if (pipe_done && out_valid_r && !out_ready) skid_res_r <= res_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_normal_x = out_res_r.normal_x;
  assign out_normal_y = out_res_r.normal_y;
  assign out_normal_z = out_res_r.normal_z;
  assign out_column   = out_res_r.column;
  assign out_row      = out_res_r.row;
  assign out_interior = out_res_r.interior;
  assign out_last_out = out_res_r.last;

`ifndef NO_ASSERTIONS
  a_skid_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_full_r) |-> $past(out_valid_r && !out_ready))
    else $error("skid entry filled without a stalled output");

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid entry full while output register empty");

  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_interior |->
      out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0)
    else $error("border pixel with nonzero normal");

  a_width_reload: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && cfg_index == REG_IMAGE_WIDTH |=> !in_ready)
    else $error("input taken during line buffer reload");
`endif

endmodule

`default_nettype wire
